// ----- design/bmf_pkg.sv -----
// ----------------------------------------------------------------------------
// bmf_pkg
// shared types, command codes and bracket decoding for the bracket match finder
// ----------------------------------------------------------------------------
package bmf_pkg;

    localparam int POS_W  = 12;
    localparam int CHAR_W = 8;
    localparam int CMD_W  = 2;

    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [POS_W-1:0]  t_pos;

    localparam t_cmd CMD_CLEAR  = 2'd0;
    localparam t_cmd CMD_APPEND = 2'd1;
    localparam t_cmd CMD_QUERY  = 2'd2;

    localparam t_char CH_PAREN_OPEN  = 8'h28;
    localparam t_char CH_PAREN_CLOSE = 8'h29;
    localparam t_char CH_BRACE_OPEN  = 8'h7B;
    localparam t_char CH_BRACE_CLOSE = 8'h7D;
    localparam t_char CH_BRACK_OPEN  = 8'h5B;
    localparam t_char CH_BRACK_CLOSE = 8'h5D;

    typedef struct packed {
        logic  is_bracket;
        logic  fwd;
        t_char partner;
    } t_kind;

    function automatic t_kind bracket_kind(input t_char b);
        t_kind k;
        k.is_bracket = 1'b1;
        k.fwd        = 1'b1;
        k.partner    = '0;
        case (b)
            CH_PAREN_OPEN:  k.partner = CH_PAREN_CLOSE;
            CH_BRACE_OPEN:  k.partner = CH_BRACE_CLOSE;
            CH_BRACK_OPEN:  k.partner = CH_BRACK_CLOSE;
            CH_PAREN_CLOSE: begin
                k.partner = CH_PAREN_OPEN;
                k.fwd     = 1'b0;
            end
            CH_BRACE_CLOSE: begin
                k.partner = CH_BRACE_OPEN;
                k.fwd     = 1'b0;
            end
            CH_BRACK_CLOSE: begin
                k.partner = CH_BRACK_OPEN;
                k.fwd     = 1'b0;
            end
            default: begin
                k.is_bracket = 1'b0;
                k.fwd        = 1'b0;
            end
        endcase
        return k;
    endfunction

endpackage

// ----- design/bmf_ram.sv -----
// ----------------------------------------------------------------------------
// bmf_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module bmf_ram #(
    parameter int   WIDTH = 8,
    parameter int   DEPTH = 4096,
    localparam int  AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/bracket_match_finder.sv -----
// ----------------------------------------------------------------------------
// bracket_match_finder
// matching-bracket search over a text view held in a character ram
// ----------------------------------------------------------------------------
// usage
//   input channel (i_in_valid / o_in_stall) carries one command word:
//     clear  - empties the view (fill count to zero), no result
//     append - stores i_char_byte at the fill position, ignored when full,
//              no result; appends are taken one word per cycle while no query runs
//     query  - looks up i_cursor_pos and returns exactly one result word
//   output channel (o_out_valid / i_out_stall) carries on_bracket, found and
//   match_pos of each query
// query steps and throughput
//   a query holds the input stalled while it runs: the look state reads the
//   cursor byte, then the scan reads the ram one entry per cycle until the
//   depth returns to zero or the edge of the view is reached, then the finish
//   state hands the word to the output register once it is free. a query off a
//   bracket skips the scan; off the view, it skips the look as well. the
//   single ram read port sets the scan rate
// reset and stall
//   reset empties the view and drops any pending result; ram contents are
//   not cleared. while the receiver stalls, a finished result waits in the
//   output register; clears and appends are still taken meanwhile
// ----------------------------------------------------------------------------
module bracket_match_finder #(
    parameter int VIEW_DEPTH = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  bmf_pkg::t_cmd        i_command,
    input  bmf_pkg::t_char       i_char_byte,
    input  bmf_pkg::t_pos        i_cursor_pos,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_on_bracket,
    output logic                 o_found,
    output bmf_pkg::t_pos        o_match_pos
);

    import bmf_pkg::*;

    localparam int AW = $clog2(VIEW_DEPTH);       // ram address
    localparam int FW = $clog2(VIEW_DEPTH + 1);   // fill count, holds the depth itself
    localparam int CW = (FW > POS_W) ? FW : POS_W; // cursor against fill compare

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOK   = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    // control state
    logic [1:0]    r_state, n_state;
    logic [FW-1:0] r_fill, n_fill;
    logic          r_out_valid, n_out_valid;

    // scan working registers
    logic [AW-1:0] r_idx, n_idx;
    logic [FW-1:0] r_depth, n_depth;
    t_char         r_self, n_self;
    t_char         r_partner, n_partner;
    logic          r_fwd, n_fwd;

    // pending result and output word
    logic          r_res_on, n_res_on;
    logic          r_res_found, n_res_found;
    t_pos          r_res_pos, n_res_pos;
    logic          r_on_bracket, n_on_bracket;
    logic          r_found, n_found;
    t_pos          r_match_pos, n_match_pos;

    // ram port
    logic          w_we;
    logic [AW-1:0] w_raddr;
    t_char         w_rdata;

    // step logic
    t_kind         w_kind;
    logic          w_fwd;
    logic          w_at_end;
    logic [AW-1:0] w_step_idx;
    logic          w_accept;
    logic          w_out_free;
    logic [CW-1:0] w_cur_ext;
    logic [CW-1:0] w_fill_ext;

    bmf_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (VIEW_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (i_char_byte),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_cur_ext  = CW'(i_cursor_pos);
    assign w_fill_ext = CW'(r_fill);

    // append writes only while idle, so no read of the same entry overlaps
    assign w_we = w_accept && (i_command == CMD_APPEND)
                  && (r_fill < FW'(VIEW_DEPTH));

    assign w_kind = bracket_kind(w_rdata);
    // in the look cycle the direction comes straight from the cursor byte
    assign w_fwd  = (r_state == ST_LOOK) ? w_kind.fwd : r_fwd;

    // next index and view edge in the scan direction
    always_comb begin
        if (w_fwd) begin
            w_at_end   = ((FW'(r_idx) + FW'(1)) >= r_fill);
            w_step_idx = r_idx + AW'(1);
        end else begin
            w_at_end   = (r_idx == '0);
            w_step_idx = r_idx - AW'(1);
        end
    end

    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_out_valid  = r_out_valid;
        n_idx        = r_idx;
        n_depth      = r_depth;
        n_self       = r_self;
        n_partner    = r_partner;
        n_fwd        = r_fwd;
        n_res_on     = r_res_on;
        n_res_found  = r_res_found;
        n_res_pos    = r_res_pos;
        n_on_bracket = r_on_bracket;
        n_found      = r_found;
        n_match_pos  = r_match_pos;

        // word taken by the receiver
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_command)
                        CMD_CLEAR: begin
                            n_fill = '0;
                        end
                        CMD_APPEND: begin
                            if (w_we) begin
                                n_fill = r_fill + FW'(1);
                            end
                        end
                        CMD_QUERY: begin
                            n_res_on    = 1'b0;
                            n_res_found = 1'b0;
                            n_res_pos   = '0;
                            if (w_cur_ext < w_fill_ext) begin
                                n_idx   = AW'(w_cur_ext);
                                n_state = ST_LOOK;
                            end else begin
                                // cursor off the view
                                n_state = ST_FINISH;
                            end
                        end
                        default: begin
                            // unused code, dropped
                        end
                    endcase
                end
            end
            ST_LOOK: begin
                // cursor byte arrives
                if (!w_kind.is_bracket) begin
                    n_state = ST_FINISH;
                end else begin
                    n_res_on  = 1'b1;
                    n_self    = w_rdata;
                    n_partner = w_kind.partner;
                    n_fwd     = w_kind.fwd;
                    n_depth   = FW'(1);
                    if (w_at_end) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_idx   = w_step_idx;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if ((w_rdata == r_partner) && (r_depth == FW'(1))) begin
                    n_res_found = 1'b1;
                    n_res_pos   = POS_W'(r_idx);
                    n_state     = ST_FINISH;
                end else begin
                    if (w_rdata == r_self) begin
                        n_depth = r_depth + FW'(1);
                    end else if (w_rdata == r_partner) begin
                        n_depth = r_depth - FW'(1);
                    end
                    if (w_at_end) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_idx = w_step_idx;
                    end
                end
            end
            ST_FINISH: begin
                // move the result into the output register once it is free
                if (w_out_free) begin
                    n_on_bracket = r_res_on;
                    n_found      = r_res_found;
                    n_match_pos  = r_res_pos;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // read the entry that the scan will look at next cycle
    assign w_raddr = n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_depth      <= n_depth;
        r_self       <= n_self;
        r_partner    <= n_partner;
        r_fwd        <= n_fwd;
        r_res_on     <= n_res_on;
        r_res_found  <= n_res_found;
        r_res_pos    <= n_res_pos;
        r_on_bracket <= n_on_bracket;
        r_found      <= n_found;
        r_match_pos  <= n_match_pos;
    end

    assign o_out_valid  = r_out_valid;
    assign o_on_bracket = r_on_bracket;
    assign o_found      = r_found;
    assign o_match_pos  = r_match_pos;

endmodule
